// ===== design/fpa_pkg.sv =====
// Shared sizes, widths and codes for the fit-policy partition allocator.
package fpa_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  // Port field widths
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int POLICY_W = 2;
  localparam int BLK_W    = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Derived widths
  localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_BITS = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
  localparam int LIM_W    = (CNT_BITS > BLK_W) ? CNT_BITS : BLK_W;
  localparam int SLT_W    = (CNT_BITS > SLOT_W) ? CNT_BITS : SLOT_W;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Placement policy codes (the unused code acts as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

endpackage

// ===== design/fpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fit_policy_partition_allocator_core.sv =====
// Fit-policy partition allocator: free-size table in RAM with a scan sequencer.
//
// Input channel (valid/stall): command, block_slot, amount. A load word writes
// the free size of one partition into the table and produces no result. A
// request word scans partitions 0 .. limit-1 (limit is blocks_in_use saturated
// to the table depth) one per cycle through the table RAM's read port, picks a
// partition by the policy register, writes the reduced size back if one fits
// and delivers one result word (granted, chosen_block, left_over). After a
// request is taken, in_stall stays high while the sequencer issues one read per
// entry, waits for the last read to return, sees the scan drained and does the
// write-back; this is set by the single read port of the table RAM.
// The input is stalled while a request is in progress; loads follow back to back.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls and a second result is ready, the block holds
// it in the write-back step until the output register frees.
// Reset clears the control state and the configuration registers (policy first
// fit, blocks_in_use 16); table entries are undefined until loaded, no clearing
// pass. The user must write configuration through cfg_write/cfg_index/cfg_data
// only while idle; the block itself does not enforce this.
module fit_policy_partition_allocator_core
  import fpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [SLOT_W-1:0]    block_slot,
  input  logic [AMOUNT_W-1:0]  amount,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 granted,
  output logic [SLOT_W-1:0]    chosen_block,
  output logic [AMOUNT_W-1:0]  left_over
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [POLICY_W-1:0] policy;
  logic [BLK_W-1:0]    blocks_in_use;

  logic [AMOUNT_W-1:0] req_amount;
  logic [CNT_BITS-1:0] issue_idx;
  logic                pending;
  logic [IDX_BITS-1:0] pend_idx;
  logic                found;
  logic [IDX_BITS-1:0] pick;
  logic [SIZE_BITS-1:0] pick_val;

  logic [CNT_BITS-1:0] limit;
  logic                in_acc;
  logic                out_free;
  logic                issue;
  logic                slot_ok;
  logic                fits;
  logic                better;
  logic [CMP_BITS-1:0] rd_ext;
  logic [CMP_BITS-1:0] amt_ext;
  logic [CMP_BITS-1:0] remain;

  // RAM ports
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  // Searched partition count, saturated to the table depth
  assign limit = (LIM_W'(blocks_in_use) > LIM_W'(NUM_BLOCKS)) ?
                 CNT_BITS'(NUM_BLOCKS) : CNT_BITS'(blocks_in_use);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == ST_SCAN) && (issue_idx < limit);
  assign slot_ok  = SLT_W'(block_slot) < SLT_W'(NUM_BLOCKS);

  // Compare stage on returned table data
  assign rd_ext  = CMP_BITS'(ram_rdata);
  assign amt_ext = CMP_BITS'(req_amount);
  assign fits    = rd_ext >= amt_ext;
  always_comb begin
    case (policy)
      POL_BEST:  better = ram_rdata < pick_val;
      POL_WORST: better = ram_rdata > pick_val;
      default:   better = 1'b0;
    endcase
  end
  assign remain = CMP_BITS'(pick_val) - amt_ext;

  // Table write: loads at accept, chosen entry at write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_BITS'(block_slot);
    ram_wdata = SIZE_BITS'(amount);
    if (state == ST_DONE) begin
      ram_we    = found && out_free;
      ram_waddr = pick;
      ram_wdata = SIZE_BITS'(remain);
    end else if (in_acc && command == CMD_LOAD) begin
      ram_we = slot_ok;
    end
  end

  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (issue_idx[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && command == CMD_REQUEST) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !pending) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POL_FIRST;
      blocks_in_use <= BLK_W'(NUM_BLOCKS > 16 ? 16 : 16);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POLICY:        policy        <= cfg_data[POLICY_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
      found   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= issue;
      if (state == ST_IDLE) begin
        found <= 1'b0;
      end else if (state == ST_SCAN && pending && fits && (!found || better)) begin
        found <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      issue_idx  <= '0;
      req_amount <= amount;
    end else if (issue) begin
      issue_idx <= issue_idx + 1'b1;
    end
    pend_idx <= issue_idx[IDX_BITS-1:0];
    if (state == ST_SCAN && pending && fits && (!found || better)) begin
      pick     <= pend_idx;
      pick_val <= ram_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      granted      <= found;
      chosen_block <= found ? SLOT_W'(pick) : '0;
      left_over    <= found ? AMOUNT_W'(remain) : '0;
    end
  end

  // Assertions
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> chosen_block == '0 && left_over == '0)
    else $error("ungranted result carries nonzero fields");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> issue_idx <= limit)
    else $error("scan ran past the searched range");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && found |-> CNT_BITS'(pick) < limit)
    else $error("chosen partition outside the searched range");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared without a finished request");

endmodule
